// ===== design/scc_pkg.sv =====
package scc_pkg;

    localparam int LIN_W   = 25;
    localparam int COEF_W  = 14;
    localparam int PROD_W  = COEF_W + LIN_W;
    localparam int SUM_W   = 38;
    localparam int TOT_W   = 39;
    localparam int TRI_W   = 15;
    localparam int CHR_W   = 16;
    localparam int Q24_SH  = 24;
    localparam int XYZ_MAX = 32767;
    localparam int CHR_MAX = 65535;
    localparam int DATA_W  = 3 * TRI_W + 2 * CHR_W;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

    typedef logic [LIN_W-1:0]  t_lin;
    typedef logic [COEF_W-1:0] t_coef;
    typedef t_lin  t_lin_tab [256];

    localparam t_coef MAT [3][3] = '{
        '{14'd4124, 14'd3576, 14'd1805},
        '{14'd2126, 14'd7152, 14'd722},
        '{14'd193,  14'd1192, 14'd9505}
    };

    function automatic logic [63:0] f_pow5(input logic [63:0] r);
        logic [63:0] a;
        a = r;
        for (int i = 0; i < 4; i++) begin
            a = (a * r) >> 30;
        end
        return a;
    endfunction

    function automatic t_lin f_lin_entry(input logic [63:0] v);
        logic [63:0] tq;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (v * 64'd100000 <= 64'd1031475) begin
            return LIN_W'((v * 64'd100 * (64'd1 << 24) + 64'd164730) / 64'd329460);
        end
        tq = (((64'd1000 * v + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        t2 = (tq * tq + (64'd1 << 29)) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            if (f_pow5(mid) <= t2) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return LIN_W'((t2 * lo + (64'd1 << 35)) >> 36);
    endfunction

    function automatic t_lin_tab f_lin_tab();
        t_lin_tab tab;
        for (int v = 0; v < 256; v++) begin
            tab[v] = f_lin_entry(64'(v));
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = f_lin_tab();

endpackage

// ===== design/scc_front.sv =====
module scc_front #(
    parameter int XYZ_FRAC_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_red,
    input  logic [7:0]                  i_green,
    input  logic [7:0]                  i_blue,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [scc_pkg::TRI_W-1:0]   o_tristim_x,
    output logic [scc_pkg::TRI_W-1:0]   o_tristim_y,
    output logic [scc_pkg::TRI_W-1:0]   o_tristim_z,
    output logic [scc_pkg::SUM_W-1:0]   o_sum_x,
    output logic [scc_pkg::SUM_W-1:0]   o_sum_y,
    output logic [scc_pkg::TOT_W-1:0]   o_total
);
    import scc_pkg::*;

    localparam int UPW = SUM_W + XYZ_FRAC_BITS + 1;
    localparam int UW  = $clog2(10000 * (2 ** XYZ_FRAC_BITS) + 51);
    localparam int K   = UW + 7;
    localparam int MW  = UW + 1;
    localparam int PW  = UW + MW;
    localparam logic [63:0] RECIP = (64'd1 << K) / 64'd100 + 64'd1;

    logic [4:0] r_v;
    logic [4:0] en;

    t_lin              r_ch [3];
    logic [PROD_W-1:0] r_p  [3][3];
    logic [SUM_W-1:0]  r_s  [3];
    logic [UW-1:0]     r_u  [3];
    logic [PW-1:0]     r_um [3];
    logic [TOT_W-1:0]  r_tot3;
    logic [TOT_W-1:0]  r_tot4;
    logic [SUM_W-1:0]  r_sx3;
    logic [SUM_W-1:0]  r_sy3;
    logic [SUM_W-1:0]  r_sx4;
    logic [SUM_W-1:0]  r_sy4;
    logic [UPW-1:0]    n_uf [3];
    logic [31:0]       n_q  [3];
    logic [TRI_W-1:0]  n_tri [3];

    assign en[4] = !r_v[4] || i_ready;
    generate
        for (genvar k = 0; k < 4; k++) begin : g_en
            assign en[k] = !r_v[k] || en[k+1];
        end
    endgenerate

    assign o_ready = en[0];
    assign o_valid = r_v[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < 5; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_uf[i]  = (UPW'(r_s[i]) << XYZ_FRAC_BITS) + (UPW'(50) << Q24_SH);
            n_q[i]   = 32'(r_um[i][PW-1:K]);
            n_tri[i] = (n_q[i] > 32'(XYZ_MAX)) ? TRI_W'(XYZ_MAX) : n_q[i][TRI_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ch[0] <= LIN_TAB[i_red];
            r_ch[1] <= LIN_TAB[i_green];
            r_ch[2] <= LIN_TAB[i_blue];
        end
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= PROD_W'(MAT[i][j]) * PROD_W'(r_ch[j]);
                end
            end
        end
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_s[i] <= SUM_W'(r_p[i][0]) + SUM_W'(r_p[i][1]) + SUM_W'(r_p[i][2]);
            end
        end
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= n_uf[i][Q24_SH +: UW];
            end
            r_tot3 <= TOT_W'(r_s[0]) + TOT_W'(r_s[1]) + TOT_W'(r_s[2]);
            r_sx3  <= r_s[0];
            r_sy3  <= r_s[1];
        end
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_um[i] <= PW'(r_u[i]) * PW'(RECIP[MW-1:0]);
            end
            r_tot4 <= r_tot3;
            r_sx4  <= r_sx3;
            r_sy4  <= r_sy3;
        end
    end

    assign o_tristim_x = n_tri[0];
    assign o_tristim_y = n_tri[1];
    assign o_tristim_z = n_tri[2];
    assign o_sum_x     = r_sx4;
    assign o_sum_y     = r_sy4;
    assign o_total     = r_tot4;

endmodule

// ===== design/scc_div.sv =====
module scc_div #(
    parameter int CHROMA_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [scc_pkg::TRI_W-1:0]   i_tristim_x,
    input  logic [scc_pkg::TRI_W-1:0]   i_tristim_y,
    input  logic [scc_pkg::TRI_W-1:0]   i_tristim_z,
    input  logic [scc_pkg::SUM_W-1:0]   i_sum_x,
    input  logic [scc_pkg::SUM_W-1:0]   i_sum_y,
    input  logic [scc_pkg::TOT_W-1:0]   i_total,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [scc_pkg::TRI_W-1:0]   o_tristim_x,
    output logic [scc_pkg::TRI_W-1:0]   o_tristim_y,
    output logic [scc_pkg::TRI_W-1:0]   o_tristim_z,
    output logic [scc_pkg::CHR_W-1:0]   o_chroma_x,
    output logic [scc_pkg::CHR_W-1:0]   o_chroma_y,
    output logic                        o_black
);
    import scc_pkg::*;

    localparam int QB = CHROMA_BITS + 1;
    localparam int NW = TOT_W + CHROMA_BITS + 1;

    logic [QB:0]       r_v;
    logic [QB:0]       en;
    logic [NW-1:0]     r_rx  [QB+1];
    logic [NW-1:0]     r_ry  [QB+1];
    logic [TOT_W-1:0]  r_tot [QB+1];
    logic [QB-1:0]     r_qx  [QB+1];
    logic [QB-1:0]     r_qy  [QB+1];
    logic              r_blk [QB+1];
    logic [TRI_W-1:0]  r_tri [QB+1][3];
    logic [31:0]       n_qx;
    logic [31:0]       n_qy;

    assign en[QB] = !r_v[QB] || i_ready;
    generate
        for (genvar k = 0; k < QB; k++) begin : g_en
            assign en[k] = !r_v[k] || en[k+1];
        end
    endgenerate

    assign o_ready = en[0];
    assign o_valid = r_v[QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= QB; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rx[0]     <= (NW'(i_sum_x) << CHROMA_BITS) + NW'(i_total >> 1);
            r_ry[0]     <= (NW'(i_sum_y) << CHROMA_BITS) + NW'(i_total >> 1);
            r_tot[0]    <= i_total;
            r_qx[0]     <= '0;
            r_qy[0]     <= '0;
            r_blk[0]    <= (i_total == '0);
            r_tri[0][0] <= i_tristim_x;
            r_tri[0][1] <= i_tristim_y;
            r_tri[0][2] <= i_tristim_z;
        end
    end

    generate
        for (genvar k = 1; k <= QB; k++) begin : g_step
            localparam int B = QB - k;
            logic [NW-1:0] n_d;
            logic          n_gx;
            logic          n_gy;

            assign n_d  = NW'(r_tot[k-1]) << B;
            assign n_gx = r_rx[k-1] >= n_d;
            assign n_gy = r_ry[k-1] >= n_d;

            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_rx[k]  <= n_gx ? r_rx[k-1] - n_d : r_rx[k-1];
                    r_ry[k]  <= n_gy ? r_ry[k-1] - n_d : r_ry[k-1];
                    r_qx[k]  <= r_qx[k-1] | (QB'(n_gx) << B);
                    r_qy[k]  <= r_qy[k-1] | (QB'(n_gy) << B);
                    r_tot[k] <= r_tot[k-1];
                    r_blk[k] <= r_blk[k-1];
                    r_tri[k] <= r_tri[k-1];
                end
            end
        end
    endgenerate

    assign n_qx = 32'(r_qx[QB]);
    assign n_qy = 32'(r_qy[QB]);

    always_comb begin
        if (r_blk[QB]) begin
            o_chroma_x = '0;
            o_chroma_y = '0;
        end else begin
            o_chroma_x = (n_qx > 32'(CHR_MAX)) ? CHR_W'(CHR_MAX) : n_qx[CHR_W-1:0];
            o_chroma_y = (n_qy > 32'(CHR_MAX)) ? CHR_W'(CHR_MAX) : n_qy[CHR_W-1:0];
        end
    end

    assign o_black     = r_blk[QB];
    assign o_tristim_x = r_tri[QB][0];
    assign o_tristim_y = r_tri[QB][1];
    assign o_tristim_z = r_tri[QB][2];

endmodule

// ===== design/srgb_to_xyz_chromaticity_core.sv =====
// Channel   Dir  Contents
// s_axis    in   tdata: red[7:0], green[15:8], blue[23:16]
// m_axis    out  tdata: X, Y, Z, x, y; tuser: black flag
//
// One word is accepted every cycle unless back-pressure on m_axis has filled the pipeline.
// The pipeline holds the linearize, matrix and XYZ scaling stages followed by one restoring
// division stage per chromaticity quotient bit.
// Reset is synchronous and active low and clears only the stage valid bits.
// Each stage holds its word while the next stage is full and stalled, so bubbles close up.
module srgb_to_xyz_chromaticity_core #(
    parameter int XYZ_FRAC_BITS = 8,
    parameter int CHROMA_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // red, green, blue
    input  logic [23:0]                   i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tristim_x, tristim_y, tristim_z, chroma_x, chroma_y, zero fill
    output logic [scc_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    // black_flag
    output logic                          o_m_axis_tuser
);
    import scc_pkg::*;

    logic             f_valid;
    logic             f_ready;
    logic [TRI_W-1:0] f_tx;
    logic [TRI_W-1:0] f_ty;
    logic [TRI_W-1:0] f_tz;
    logic [SUM_W-1:0] f_sx;
    logic [SUM_W-1:0] f_sy;
    logic [TOT_W-1:0] f_tot;
    logic [TRI_W-1:0] d_tx;
    logic [TRI_W-1:0] d_ty;
    logic [TRI_W-1:0] d_tz;
    logic [CHR_W-1:0] d_cx;
    logic [CHR_W-1:0] d_cy;

    scc_front #(.XYZ_FRAC_BITS(XYZ_FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_red      (i_s_axis_tdata[7:0]),
        .i_green    (i_s_axis_tdata[15:8]),
        .i_blue     (i_s_axis_tdata[23:16]),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_tristim_x(f_tx),
        .o_tristim_y(f_ty),
        .o_tristim_z(f_tz),
        .o_sum_x    (f_sx),
        .o_sum_y    (f_sy),
        .o_total    (f_tot)
    );

    scc_div #(.CHROMA_BITS(CHROMA_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .o_ready    (f_ready),
        .i_tristim_x(f_tx),
        .i_tristim_y(f_ty),
        .i_tristim_z(f_tz),
        .i_sum_x    (f_sx),
        .i_sum_y    (f_sy),
        .i_total    (f_tot),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_tristim_x(d_tx),
        .o_tristim_y(d_ty),
        .o_tristim_z(d_tz),
        .o_chroma_x (d_cx),
        .o_chroma_y (d_cy),
        .o_black    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {(TDATA_W - DATA_W)'(0), d_cy, d_cx, d_tz, d_ty, d_tx};

endmodule

// ===== verif/srgb_to_xyz_chromaticity_core_tb.sv =====
module srgb_to_xyz_chromaticity_core_tb;
    import scc_pkg::*;

    typedef struct packed {
        logic [TRI_W-1:0] tri_x;
        logic [TRI_W-1:0] tri_y;
        logic [TRI_W-1:0] tri_z;
        logic [CHR_W-1:0] chr_x;
        logic [CHR_W-1:0] chr_y;
        logic             black;
    } t_xyz;

    class xyz_scoreboard;
        t_xyz        pending[$];
        logic [63:0] curve[256];
        int          errors;
        int          matched;

        function logic [63:0] pow5(logic [63:0] r);
            logic [63:0] a;
            a = r;
            repeat (4) a = (a * r) >> 30;
            return a;
        endfunction

        function logic [63:0] linearize(int v);
            logic [63:0] tq;
            logic [63:0] t2;
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] mid;
            if (v <= 10) begin
                return (64'(v) * 100 * (64'd1 << 24) + 164730) / 329460;
            end
            tq = (((64'(v) * 1000 + 14025) << 30) + 134512) / 269025;
            t2 = (tq * tq + (64'd1 << 29)) >> 30;
            lo = 0;
            hi = 64'd1 << 30;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                if (pow5(mid) <= t2) lo = mid;
                else hi = mid - 1;
            end
            return (t2 * lo + (64'd1 << 35)) >> 36;
        endfunction

        function void build_curve();
            for (int v = 0; v < 256; v++) curve[v] = linearize(v);
        endfunction

        function void note_pixel(logic [23:0] px);
            logic [63:0] lin[3];
            logic [63:0] s[3];
            logic [63:0] tot;
            logic [63:0] q;
            logic [63:0] d;
            int          wt[3][3];
            t_xyz        e;
            wt = '{'{4124, 3576, 1805}, '{2126, 7152, 722}, '{193, 1192, 9505}};
            d = 64'd100 << 24;
            for (int i = 0; i < 3; i++) lin[i] = curve[px[8*i +: 8]];
            for (int i = 0; i < 3; i++) begin
                s[i] = 0;
                for (int j = 0; j < 3; j++) s[i] += 64'(wt[i][j]) * lin[j];
            end
            tot = s[0] + s[1] + s[2];
            q = ((s[0] << 8) + d / 2) / d;
            e.tri_x = TRI_W'(q > 64'd32767 ? 64'd32767 : q);
            q = ((s[1] << 8) + d / 2) / d;
            e.tri_y = TRI_W'(q > 64'd32767 ? 64'd32767 : q);
            q = ((s[2] << 8) + d / 2) / d;
            e.tri_z = TRI_W'(q > 64'd32767 ? 64'd32767 : q);
            if (tot == 0) begin
                e.chr_x = '0; e.chr_y = '0; e.black = 1'b1;
            end else begin
                q = ((s[0] << 16) + tot / 2) / tot;
                e.chr_x = CHR_W'(q > 64'd65535 ? 64'd65535 : q);
                q = ((s[1] << 16) + tot / 2) / tot;
                e.chr_y = CHR_W'(q > 64'd65535 ? 64'd65535 : q);
                e.black = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check_word(logic [TDATA_W-1:0] dat, logic usr);
            t_xyz a;
            t_xyz e;
            a.tri_x = dat[0 +: TRI_W];
            a.tri_y = dat[TRI_W +: TRI_W];
            a.tri_z = dat[2*TRI_W +: TRI_W];
            a.chr_x = dat[3*TRI_W +: CHR_W];
            a.chr_y = dat[3*TRI_W+CHR_W +: CHR_W];
            a.black = usr;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            matched++;
            if (a.tri_x !== e.tri_x) report("X", 32'(e.tri_x), 32'(a.tri_x));
            if (a.tri_y !== e.tri_y) report("Y", 32'(e.tri_y), 32'(a.tri_y));
            if (a.tri_z !== e.tri_z) report("Z", 32'(e.tri_z), 32'(a.tri_z));
            if (a.chr_x !== e.chr_x) report("x", 32'(e.chr_x), 32'(a.chr_x));
            if (a.chr_y !== e.chr_y) report("y", 32'(e.chr_y), 32'(a.chr_y));
            if (a.black !== e.black) report("black", 32'(e.black), 32'(a.black));
        endfunction

        function void report(string f, logic [31:0] e, logic [31:0] a);
            $display("%0t: %s expected %0d actual %0d", $time, f, e, a);
            errors++;
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [23:0]        s_data = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [TDATA_W-1:0] m_data;
    logic               m_user;
    xyz_scoreboard      sb;
    logic [23:0]        pixels[$];
    bit                 hold_off = 0;
    int                 idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    srgb_to_xyz_chromaticity_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready) sb.note_pixel(s_data);
            if (m_valid && m_ready) sb.check_word(m_data, m_user);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 2000) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) m_ready <= 0;
        else case ($urandom_range(0, 3))
            0: m_ready <= 1'($urandom_range(0, 1));
            1: m_ready <= ($urandom_range(0, 7) != 0);
            default: m_ready <= 1;
        endcase
    end

    task automatic send_pixels();
        int burst;
        while (pixels.size() > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && pixels.size() > 0) begin
                s_valid <= 1;
                s_data <= pixels.pop_front();
                do @(posedge i_clk); while (!s_ready);
                @(negedge i_clk);
                burst--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        s_valid <= 0;
    endtask

    initial begin
        sb = new();
        sb.build_curve();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        pixels = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                   24'h0A0A0A, 24'h0B0B0B, 24'h01_00_00, 24'h000100, 24'h000001,
                   24'h0A0B0A, 24'h808080, 24'hFF00FF, 24'hAA55AA, 24'h55AA55};
        for (int i = 0; i < 1800; i++) begin
            case ($urandom_range(0, 4))
                0: pixels.push_back({3{8'($urandom_range(0, 12))}});
                1: pixels.push_back(24'($urandom_range(0, 255)) << (8 * $urandom_range(0, 2)));
                default: pixels.push_back(24'($urandom));
            endcase
            if (i == 300) pixels.push_back(24'h000000);
        end
        fork
            send_pixels();
            begin
                repeat (400) @(negedge i_clk);
                hold_off = 1;
                repeat (150) @(negedge i_clk);
                hold_off = 0;
            end
        join
        while (sb.pending.size() > 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("Checked %0d XYZ/xy words from %0d pixels, with directed extremes,",
                 sb.matched, 1816);
        $display("random bursts, output stalls and a long back-pressure stretch.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
